>>> hdl/llsa_pkg.sv
package llsa_pkg;

    // default table size
    localparam int SLOTS_DEF = 16;

    // port spacing between neighbouring slots
    localparam int PORT_STEP = 2;

    localparam int ACT_W    = 3;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int DATA_W   = 32;
    localparam int PORT_W   = 16;
    localparam int SEL_W    = 8;

    // request codes
    localparam logic [ACT_W-1:0] ACT_REGISTER   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CONFIRM    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ASSIGN_MIN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ASSIGN_NODE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELEASE    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DISCONNECT = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADIDX  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIVE    = 3'd5;

endpackage

>>> hdl/least_loaded_slot_allocator.sv
// least loaded slot allocator
//
// requests arrive on the s_ stream (s_tvalid / s_tready / s_tdata) and each
// one gives exactly one result on the m_ stream (m_tvalid / m_tready /
// m_tdata). the user writes base_port with base_port_we only while idle (unchecked).
//
// one request is handled at a time; s_tready is high only when the
// sequencer is idle. register, assign and disconnect walk the slot table
// one entry a cycle through the single read port of the slot memory,
// ending early on a match unless seeking the least load; confirm and
// release check the chosen slot. refusals and unknown codes skip the
// read of the slot, and the write step posts the result once the output
// register is free. one shared 33-bit add/subtract unit does the load
// compares, the saturating add, the release check and the port sum.
//
// reset frees every slot, clears the live flags, drops any pending result
// and sets base_port to zero. the slot contents themselves are not reset.
// if the receiver stalls, the result waits in the output register; the
// next request may be taken meanwhile but its result stays in the write
// step until the output register is free.
module least_loaded_slot_allocator
    import llsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,

    // configuration
    input  logic         base_port_we,
    input  logic [15:0]  base_port,

    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[2:0], node_id[34:3], instance_id[66:35], worker_ip[98:67],
    // slot_sel[106:99], cap_count[138:107], zero fill[143:139]
    input  logic [143:0] s_tdata,

    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok[0], status[3:1], slot_out[7:4], node_out[39:8],
    // instance_out[71:40], ip_out[103:72], port_out[119:104]
    output logic [119:0] m_tdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIRECT = 5'b00010,
        S_SCAN   = 5'b00100,
        S_READ   = 5'b01000,
        S_WRITE  = 5'b10000
    } state_t;

    // sequencer and flags
    state_t                state_reg, state_next;
    logic [15:0]           base_port_reg, base_port_next;
    logic [SLOTS-1:0]      occupied_reg, occupied_next;
    logic [SLOTS-1:0]      live_reg, live_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic                  found_reg, found_next;
    logic                  fail_reg, fail_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // request fields and working values
    logic [ACT_W-1:0]      act_reg, act_next;
    logic [DATA_W-1:0]     node_reg, node_next;
    logic [DATA_W-1:0]     inst_reg, inst_next;
    logic [DATA_W-1:0]     ip_reg, ip_next;
    logic [SEL_W-1:0]      sel_reg, sel_next;
    logic [DATA_W-1:0]     cap_reg, cap_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [DATA_W-1:0]     best_load_reg, best_load_next;
    logic [STATUS_W-1:0]   fail_code_reg, fail_code_next;

    // result register
    logic                  out_ok_reg, out_ok_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [DATA_W-1:0]     out_node_reg, out_node_next;
    logic [DATA_W-1:0]     out_inst_reg, out_inst_next;
    logic [DATA_W-1:0]     out_ip_reg, out_ip_next;
    logic [PORT_W-1:0]     out_port_reg, out_port_next;

    // slot memory, one read port with registered data
    logic [DATA_W-1:0]     node_mem_reg [SLOTS];
    logic [DATA_W-1:0]     inst_mem_reg [SLOTS];
    logic [DATA_W-1:0]     ip_mem_reg   [SLOTS];
    logic [PORT_W-1:0]     port_mem_reg [SLOTS];
    logic [DATA_W-1:0]     load_mem_reg [SLOTS];
    logic [DATA_W-1:0]     rd_node_reg;
    logic [DATA_W-1:0]     rd_inst_reg;
    logic [DATA_W-1:0]     rd_ip_reg;
    logic [PORT_W-1:0]     rd_port_reg;
    logic [DATA_W-1:0]     rd_load_reg;

    logic [IDX_W-1:0]      rd_addr;
    logic                  we_full;
    logic                  we_load;
    logic [DATA_W-1:0]     wr_load;
    logic [PORT_W-1:0]     wr_port;

    // shared add/subtract unit
    logic [DATA_W:0]       alu_a;
    logic [DATA_W:0]       alu_b;
    logic                  alu_sub;
    logic [DATA_W:0]       alu_res;

    logic                  node_eq;
    logic                  cmp_occ;
    logic                  cmp_live;
    logic                  sel_in_range;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W+3:0]      tgt_ext;
    logic                  out_free;

    assign alu_res  = alu_a + (alu_b ^ {(DATA_W+1){alu_sub}}) + {{DATA_W{1'b0}}, alu_sub};

    assign node_eq      = (rd_node_reg == node_reg);
    assign cmp_occ      = occupied_reg[cmp_idx_reg];
    assign cmp_live     = live_reg[cmp_idx_reg];
    assign sel_in_range = ({1'b0, sel_reg} < 9'(SLOTS));
    assign sel_idx      = sel_reg[IDX_W-1:0];
    assign tgt_ext      = {4'b0000, tgt_reg};
    assign out_free     = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_port_reg, out_ip_reg, out_inst_reg, out_node_reg,
                       out_slot_reg, out_status_reg, out_ok_reg};

    // read address: walking index during the scan, chosen slot otherwise
    assign rd_addr = (state_reg == S_SCAN) ? scan_cnt_reg[IDX_W-1:0] : tgt_reg;

    // operand selection for the shared unit
    always_comb
    begin
        alu_a   = {1'b0, rd_load_reg};
        alu_b   = {1'b0, cap_reg};
        alu_sub = 1'b0;
        if (state_reg == S_SCAN)
        begin
            // borrow means the candidate load is below the best so far
            alu_b   = {1'b0, best_load_reg};
            alu_sub = 1'b1;
        end
        else if (act_reg == ACT_REGISTER)
        begin
            alu_a = (DATA_W+1)'(base_port_reg);
            alu_b = (DATA_W+1)'(tgt_reg) * (DATA_W+1)'(PORT_STEP);
        end
        else if (act_reg == ACT_RELEASE)
        begin
            alu_sub = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        base_port_next  = base_port_we ? base_port : base_port_reg;
        occupied_next   = occupied_reg;
        live_next       = live_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        found_next      = found_reg;
        fail_next       = fail_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        act_next        = act_reg;
        node_next       = node_reg;
        inst_next       = inst_reg;
        ip_next         = ip_reg;
        sel_next        = sel_reg;
        cap_next        = cap_reg;
        cmp_idx_next    = cmp_idx_reg;
        tgt_next        = tgt_reg;
        best_load_next  = best_load_reg;
        fail_code_next  = fail_code_reg;

        out_ok_next     = out_ok_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_node_next   = out_node_reg;
        out_inst_next   = out_inst_reg;
        out_ip_next     = out_ip_reg;
        out_port_next   = out_port_reg;

        we_full = 1'b0;
        we_load = 1'b0;
        wr_load = alu_res[DATA_W-1:0];
        wr_port = alu_res[PORT_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next      = s_tdata[2:0];
                    node_next     = s_tdata[34:3];
                    inst_next     = s_tdata[66:35];
                    ip_next       = s_tdata[98:67];
                    sel_next      = s_tdata[106:99];
                    cap_next      = s_tdata[138:107];
                    scan_cnt_next = '0;
                    cmp_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    fail_next     = 1'b0;
                    case (s_tdata[2:0])
                        ACT_REGISTER, ACT_ASSIGN_MIN, ACT_ASSIGN_NODE, ACT_DISCONNECT:
                        begin
                            state_next = S_SCAN;
                        end
                        ACT_CONFIRM, ACT_RELEASE:
                        begin
                            state_next = S_DIRECT;
                        end
                        default:
                        begin
                            fail_next      = 1'b1;
                            fail_code_next = ST_NOMATCH;
                            state_next     = S_WRITE;
                        end
                    endcase
                end
            end

            S_DIRECT:
            begin
                tgt_next = sel_idx;
                if (!sel_in_range || !occupied_reg[sel_idx])
                begin
                    fail_next      = 1'b1;
                    fail_code_next = ST_BADIDX;
                    state_next     = S_WRITE;
                end
                else if (act_reg == ACT_CONFIRM && live_reg[sel_idx])
                begin
                    fail_next      = 1'b1;
                    fail_code_next = ST_LIVE;
                    state_next     = S_WRITE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end

            S_SCAN:
            begin
                // issue the next read while the previous slot is judged
                if (scan_cnt_reg != CNT_W'(SLOTS))
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                if (cmp_vld_reg)
                begin
                    case (act_reg)
                        ACT_REGISTER:
                        begin
                            if (!cmp_occ)
                            begin
                                found_next = 1'b1;
                                tgt_next   = cmp_idx_reg;
                                state_next = S_READ;
                            end
                        end
                        ACT_ASSIGN_MIN:
                        begin
                            // strict compare keeps the lowest index on ties
                            if (cmp_occ && cmp_live && (!found_reg || alu_res[DATA_W]))
                            begin
                                found_next     = 1'b1;
                                tgt_next       = cmp_idx_reg;
                                best_load_next = rd_load_reg;
                            end
                        end
                        ACT_ASSIGN_NODE:
                        begin
                            if (cmp_occ && cmp_live && node_eq)
                            begin
                                found_next = 1'b1;
                                tgt_next   = cmp_idx_reg;
                                state_next = S_READ;
                            end
                        end
                        ACT_DISCONNECT:
                        begin
                            if (cmp_occ && node_eq)
                            begin
                                found_next = 1'b1;
                                tgt_next   = cmp_idx_reg;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
                else if (scan_cnt_reg == CNT_W'(SLOTS))
                begin
                    // walk finished without an early exit
                    if (found_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        fail_next      = 1'b1;
                        fail_code_next = (act_reg == ACT_REGISTER) ? ST_FULL : ST_NOMATCH;
                        state_next     = S_WRITE;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                    out_ok_next     = 1'b1;
                    out_status_next = ST_OK;
                    out_slot_next   = tgt_ext[3:0];
                    out_node_next   = rd_node_reg;
                    out_inst_next   = rd_inst_reg;
                    out_ip_next     = rd_ip_reg;
                    out_port_next   = rd_port_reg;
                    if (fail_reg)
                    begin
                        out_ok_next     = 1'b0;
                        out_status_next = fail_code_reg;
                        out_slot_next   = '0;
                        out_node_next   = '0;
                        out_inst_next   = '0;
                        out_ip_next     = '0;
                        out_port_next   = '0;
                    end
                    else
                    begin
                        case (act_reg)
                            ACT_REGISTER:
                            begin
                                we_full                = 1'b1;
                                wr_load                = '0;
                                occupied_next[tgt_reg] = 1'b1;
                                live_next[tgt_reg]     = 1'b0;
                                out_node_next          = node_reg;
                                out_inst_next          = inst_reg;
                                out_ip_next            = ip_reg;
                                out_port_next          = alu_res[PORT_W-1:0];
                            end
                            ACT_CONFIRM:
                            begin
                                live_next[tgt_reg] = 1'b1;
                            end
                            ACT_ASSIGN_MIN, ACT_ASSIGN_NODE:
                            begin
                                // saturate on carry out
                                we_load = 1'b1;
                                wr_load = alu_res[DATA_W] ? {DATA_W{1'b1}}
                                                          : alu_res[DATA_W-1:0];
                            end
                            ACT_RELEASE:
                            begin
                                if (alu_res[DATA_W])
                                begin
                                    // more released than held
                                    out_ok_next     = 1'b0;
                                    out_status_next = ST_OVER;
                                    out_slot_next   = '0;
                                    out_node_next   = '0;
                                    out_inst_next   = '0;
                                    out_ip_next     = '0;
                                    out_port_next   = '0;
                                end
                                else
                                begin
                                    we_load = 1'b1;
                                end
                            end
                            ACT_DISCONNECT:
                            begin
                                occupied_next[tgt_reg] = 1'b0;
                                live_next[tgt_reg]     = 1'b0;
                            end
                            default:
                            begin
                                we_load = 1'b0;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_port_reg <= '0;
            occupied_reg  <= '0;
            live_reg      <= '0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            fail_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_port_reg <= base_port_next;
            occupied_reg  <= occupied_next;
            live_reg      <= live_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            fail_reg      <= fail_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        node_reg       <= node_next;
        inst_reg       <= inst_next;
        ip_reg         <= ip_next;
        sel_reg        <= sel_next;
        cap_reg        <= cap_next;
        cmp_idx_reg    <= cmp_idx_next;
        tgt_reg        <= tgt_next;
        best_load_reg  <= best_load_next;
        fail_code_reg  <= fail_code_next;
        out_ok_reg     <= out_ok_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_node_reg   <= out_node_next;
        out_inst_reg   <= out_inst_next;
        out_ip_reg     <= out_ip_next;
        out_port_reg   <= out_port_next;
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (we_full)
        begin
            node_mem_reg[tgt_reg] <= node_reg;
            inst_mem_reg[tgt_reg] <= inst_reg;
            ip_mem_reg[tgt_reg]   <= ip_reg;
            port_mem_reg[tgt_reg] <= wr_port;
        end
        if (we_full || we_load)
        begin
            load_mem_reg[tgt_reg] <= wr_load;
        end
        rd_node_reg <= node_mem_reg[rd_addr];
        rd_inst_reg <= inst_mem_reg[rd_addr];
        rd_ip_reg   <= ip_mem_reg[rd_addr];
        rd_port_reg <= port_mem_reg[rd_addr];
        rd_load_reg <= load_mem_reg[rd_addr];
    end

endmodule

>>> tb/sv/least_loaded_slot_allocator_test.sv
module least_loaded_slot_allocator_test
    import llsa_pkg::*;
();

    // request codes the block does not decode
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    // request fields, last field in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] cap_count;
        logic [SEL_W-1:0]  slot_sel;
        logic [DATA_W-1:0] worker_ip;
        logic [DATA_W-1:0] instance_id;
        logic [DATA_W-1:0] node_id;
        logic [ACT_W-1:0]  action;
    } alloc_req_t;

    // result fields, last field in the lowest bits
    typedef struct packed {
        logic [PORT_W-1:0]   port_out;
        logic [DATA_W-1:0]   ip_out;
        logic [DATA_W-1:0]   instance_out;
        logic [DATA_W-1:0]   node_out;
        logic [SLOT_W-1:0]   slot_out;
        logic [STATUS_W-1:0] status;
        logic                ok;
    } alloc_res_t;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

    // shadow slot table and queue of awaited results
    class slot_ledger;
        logic [PORT_W-1:0] base_port;
        bit                occupied [SLOTS_DEF];
        bit                live [SLOTS_DEF];
        logic [DATA_W-1:0] node [SLOTS_DEF];
        logic [DATA_W-1:0] inst [SLOTS_DEF];
        logic [DATA_W-1:0] addr [SLOTS_DEF];
        logic [PORT_W-1:0] port [SLOTS_DEF];
        logic [DATA_W-1:0] load [SLOTS_DEF];
        alloc_res_t        expected_results [$];
        int                mismatches;
        int                results_seen;

        function new();
            base_port = '0;
            mismatches = 0;
            results_seen = 0;
            foreach (occupied[i])
            begin
                occupied[i] = 1'b0;
                live[i] = 1'b0;
                node[i] = '0;
                inst[i] = '0;
                addr[i] = '0;
                port[i] = '0;
                load[i] = '0;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function alloc_res_t slot_view(int idx);
            alloc_res_t v;
            v.ok = 1'b1;
            v.status = ST_OK;
            v.slot_out = SLOT_W'(idx);
            v.node_out = node[idx];
            v.instance_out = inst[idx];
            v.ip_out = addr[idx];
            v.port_out = port[idx];
            return v;
        endfunction

        // saturating add into the load count
        function void add_load(int idx, logic [DATA_W-1:0] cap);
            logic [DATA_W:0] sum;
            sum = {1'b0, load[idx]} + {1'b0, cap};
            load[idx] = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        endfunction

        function alloc_res_t predict(alloc_req_t r);
            alloc_res_t res;
            bit found;
            int best;
            int i;
            res = '0;
            found = 1'b0;
            best = 0;
            case (r.action)
                ACT_REGISTER:
                begin
                    res.status = ST_FULL;
                    for (i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (!found && !occupied[i])
                        begin
                            found = 1'b1;
                            occupied[i] = 1'b1;
                            live[i] = 1'b0;
                            node[i] = r.node_id;
                            inst[i] = r.instance_id;
                            addr[i] = r.worker_ip;
                            port[i] = base_port + PORT_W'(PORT_STEP * i);
                            load[i] = '0;
                            res = slot_view(i);
                        end
                    end
                end
                ACT_CONFIRM:
                begin
                    if (r.slot_sel >= SLOTS_DEF || !occupied[r.slot_sel])
                        res.status = ST_BADIDX;
                    else if (live[r.slot_sel])
                        res.status = ST_LIVE;
                    else
                    begin
                        live[r.slot_sel] = 1'b1;
                        res = slot_view(r.slot_sel);
                    end
                end
                ACT_ASSIGN_MIN:
                begin
                    for (i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (occupied[i] && live[i] && (!found || load[i] < load[best]))
                        begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        add_load(best, r.cap_count);
                        res = slot_view(best);
                    end
                    else
                        res.status = ST_NOMATCH;
                end
                ACT_ASSIGN_NODE:
                begin
                    res.status = ST_NOMATCH;
                    for (i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (!found && occupied[i] && live[i] && node[i] == r.node_id)
                        begin
                            found = 1'b1;
                            add_load(i, r.cap_count);
                            res = slot_view(i);
                        end
                    end
                end
                ACT_RELEASE:
                begin
                    if (r.slot_sel >= SLOTS_DEF || !occupied[r.slot_sel])
                        res.status = ST_BADIDX;
                    else if (r.cap_count > load[r.slot_sel])
                        res.status = ST_OVER;
                    else
                    begin
                        load[r.slot_sel] = load[r.slot_sel] - r.cap_count;
                        res = slot_view(r.slot_sel);
                    end
                end
                ACT_DISCONNECT:
                begin
                    res.status = ST_NOMATCH;
                    for (i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (!found && occupied[i] && node[i] == r.node_id)
                        begin
                            found = 1'b1;
                            res = slot_view(i);
                            occupied[i] = 1'b0;
                            live[i] = 1'b0;
                            load[i] = '0;
                        end
                    end
                end
                default:
                    res.status = ST_NOMATCH;
            endcase
            return res;
        endfunction

        function void note_request(alloc_req_t r);
            expected_results.push_back(predict(r));
        endfunction

        task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            mismatches++;
            $display("mismatch in result %0d, %s: got %h, want %h",
                     results_seen, what, got, want);
        endtask

        task check_result(alloc_res_t got);
            alloc_res_t want;
            results_seen++;
            if (expected_results.size() == 0)
                report("result with no request waiting", DATA_W'(got.status), '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok)
                    report("ok", DATA_W'(got.ok), DATA_W'(want.ok));
                if (got.status !== want.status)
                    report("status", DATA_W'(got.status), DATA_W'(want.status));
                if (got.slot_out !== want.slot_out)
                    report("slot_out", DATA_W'(got.slot_out), DATA_W'(want.slot_out));
                if (got.node_out !== want.node_out)
                    report("node_out", got.node_out, want.node_out);
                if (got.instance_out !== want.instance_out)
                    report("instance_out", got.instance_out, want.instance_out);
                if (got.ip_out !== want.ip_out)
                    report("ip_out", got.ip_out, want.ip_out);
                if (got.port_out !== want.port_out)
                    report("port_out", DATA_W'(got.port_out), DATA_W'(want.port_out));
            end
        endtask
    endclass

    // run limits and traffic shape
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 30;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 120;
    localparam int IDLE_PCT    = 19;
    localparam int POOL_SIZE   = 6;
    localparam int REQ_W       = 144;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               base_port_we = 1'b0;
    logic [PORT_W-1:0]  base_port = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // action, node_id, instance_id, worker_ip, slot_sel, cap_count, zero fill
    logic [REQ_W-1:0]   s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // ok, status, slot_out, node_out, instance_out, ip_out, port_out
    logic [119:0]       m_tdata;

    // no idling on either side while set
    bit                 quiet = 1'b0;
    // asks the result side for one long hold-off
    bit                 hold_ask = 1'b0;
    int                 cycle_count = 0;
    // small node pool so that node lookups and disconnects find matches
    logic [DATA_W-1:0]  node_pool [POOL_SIZE];
    slot_ledger         ledger = new();

    least_loaded_slot_allocator u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_port_we (base_port_we),
        .base_port    (base_port),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always #2 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("least_loaded_slot_allocator_test: FAIL");
            $finish;
        end
    end

    // offer one request and hold it until the block takes it
    task automatic send_request(input alloc_req_t r);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(REQ_W - $bits(alloc_req_t)){1'b0}}, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // taken at this edge, so the shadow table moves on now
        ledger.note_request(r);
    endtask

    task automatic send_fields(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] nd,
                               input logic [DATA_W-1:0] ins, input logic [DATA_W-1:0] ip,
                               input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] cap);
        alloc_req_t r;
        r.action = act;
        r.node_id = nd;
        r.instance_id = ins;
        r.worker_ip = ip;
        r.slot_sel = sel;
        r.cap_count = cap;
        send_request(r);
    endtask

    // stop offering, let every awaited result come back, then settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // register write, only ever called with the block idle
    task automatic write_base_port(input logic [PORT_W-1:0] value);
        base_port_we <= 1'b1;
        base_port    <= value;
        @(posedge clk);
        base_port_we <= 1'b0;
        ledger.base_port = value;
    endtask

    // weighted choice of request code for the phase's traffic mix
    function automatic logic [ACT_W-1:0] pick_action(mix_t mix);
        int weights [7];
        logic [ACT_W-1:0] codes [7];
        int roll;
        int acc;
        int k;
        bit chosen;
        logic [ACT_W-1:0] pick;
        codes = '{ACT_REGISTER, ACT_CONFIRM, ACT_ASSIGN_MIN, ACT_ASSIGN_NODE,
                  ACT_RELEASE, ACT_DISCONNECT, ACT_SPARE_LO};
        case (mix)
            MIX_FILL:     weights = '{45, 25, 8, 8, 6, 4, 4};
            MIX_BALANCED: weights = '{18, 16, 20, 16, 16, 10, 4};
            default:      weights = '{8, 10, 15, 12, 15, 36, 4};
        endcase
        roll = $urandom_range(0, 99);
        acc = 0;
        chosen = 1'b0;
        pick = ACT_SPARE_LO;
        for (k = 0; k < 7; k++)
        begin
            if (!chosen && roll < acc + weights[k])
            begin
                chosen = 1'b1;
                pick = codes[k];
            end
            acc += weights[k];
        end
        // undecoded codes: either of the two spares
        if (pick == ACT_SPARE_LO && $urandom_range(0, 1) == 1)
            pick = ACT_SPARE_HI;
        return pick;
    endfunction

    function automatic alloc_req_t random_request(mix_t mix);
        alloc_req_t r;
        int roll;
        r.action = pick_action(mix);
        if ($urandom_range(0, 99) < 85)
            r.node_id = node_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            r.node_id = $urandom();
        r.instance_id = $urandom();
        r.worker_ip = $urandom();
        // mostly valid slot numbers, sometimes anywhere in the byte
        if ($urandom_range(0, 99) < 90)
            r.slot_sel = SEL_W'($urandom_range(0, SLOTS_DEF - 1));
        else
            r.slot_sel = SEL_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (r.action == ACT_RELEASE)
        begin
            // small releases mostly succeed, wide ones test the over-release check
            if (roll < 60)
                r.cap_count = $urandom_range(0, 300);
            else if (roll < 85)
                r.cap_count = $urandom_range(0, 20);
            else
                r.cap_count = $urandom();
        end
        else
        begin
            // a share of huge amounts drives loads into saturation
            if (roll < 70)
                r.cap_count = $urandom_range(0, 500);
            else if (roll < 90)
                r.cap_count = $urandom();
            else
                r.cap_count = 32'hFFFF_FF00 | $urandom_range(0, 255);
        end
        return r;
    endfunction

    // result side: checks each result taken and stalls at random, or for
    // one long hold-off so that the block backs up into its request side
    initial
    begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready)
                ledger.check_result(alloc_res_t'(m_tdata));
            if (hold_ask && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        int p;
        int n;
        mix_t mix;
        for (n = 0; n < POOL_SIZE; n++)
            node_pool[n] = $urandom();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base near the top so that listen ports wrap
        write_base_port(16'hFFF0);

        // empty table: nothing live, free slots refused
        send_fields(ACT_ASSIGN_MIN, '0, '0, '0, '0, 32'd5);
        send_fields(ACT_CONFIRM, '0, '0, '0, 8'd0, '0);
        send_fields(ACT_RELEASE, '0, '0, '0, 8'd0, '0);
        // field extremes on registration
        send_fields(ACT_REGISTER, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_fields(ACT_REGISTER, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h00, 32'h0);
        // confirm out of range, fresh, and already live
        send_fields(ACT_CONFIRM, '0, '0, '0, 8'd255, '0);
        send_fields(ACT_CONFIRM, '0, '0, '0, 8'd16, '0);
        send_fields(ACT_CONFIRM, '0, '0, '0, 8'd0, '0);
        send_fields(ACT_CONFIRM, '0, '0, '0, 8'd0, '0);
        send_fields(ACT_CONFIRM, '0, '0, '0, 8'd1, '0);
        // equal loads go to the lower slot, then saturation of the load
        send_fields(ACT_ASSIGN_MIN, '0, '0, '0, '0, 32'd0);
        send_fields(ACT_ASSIGN_MIN, '0, '0, '0, '0, 32'hFFFF_FFFF);
        send_fields(ACT_ASSIGN_NODE, 32'h0, '0, '0, '0, 32'd1);
        send_fields(ACT_ASSIGN_MIN, '0, '0, '0, '0, 32'd7);
        send_fields(ACT_ASSIGN_NODE, 32'h1234_5678, '0, '0, '0, 32'd3);
        // release above the load, the whole load, and out of range
        send_fields(ACT_RELEASE, '0, '0, '0, 8'd1, 32'd8);
        send_fields(ACT_RELEASE, '0, '0, '0, 8'd0, 32'hFFFF_FFFF);
        send_fields(ACT_RELEASE, '0, '0, '0, 8'd255, 32'd0);
        // disconnect frees the slot, a second one finds nothing
        send_fields(ACT_DISCONNECT, 32'h0, '0, '0, '0, '0);
        send_fields(ACT_DISCONNECT, 32'h0, '0, '0, '0, '0);
        // reused slot comes back not live with no load
        send_fields(ACT_REGISTER, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hC0A8_0001, '0, '0);
        send_fields(ACT_ASSIGN_NODE, 32'hA5A5_A5A5, '0, '0, '0, 32'd9);
        send_fields(ACT_SPARE_LO, '0, '0, '0, '0, '0);
        send_fields(ACT_SPARE_HI, '0, '0, '0, '0, '0);
        wait_drained();

        // random phases; the table is refilled, churned and drained in turn
        for (p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       mix = MIX_FILL;
                3:       mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            if (p == 0)
                write_base_port(16'h0000);
            else if (p == 1)
                write_base_port(16'hFFFF);
            else
                write_base_port(PORT_W'($urandom_range(0, 65535)));
            // swap one pool entry so old nodes still get matched
            node_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
            quiet <= (p == 5);
            if (p == 3)
                hold_ask <= 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(mix));
            wait_drained();
        end

        if (ledger.mismatches == 0)
            $display("least_loaded_slot_allocator_test: PASS");
        else
            $display("least_loaded_slot_allocator_test: FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/llsa_pkg.sv
hdl/least_loaded_slot_allocator.sv
tb/sv/least_loaded_slot_allocator_test.sv
